// File: design/pcs_pkg.sv
// shared types and constants for the pearson correlation statistics block
// no dependencies
package pcs_pkg;

  localparam int MAX_PAIRS   = 65536;
  localparam int SAMPLE_BITS = 16;
  localparam int ROOT_W      = 158;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_ZVAR = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // closed run: count and exact sums
  typedef struct packed {
    logic        [16:0] cnt;
    logic signed [32:0] sa;
    logic signed [32:0] sb;
    logic        [46:0] saa;
    logic        [46:0] sbb;
    logic signed [47:0] sab;
  } pcs_run_t;

  typedef struct packed {
    logic signed [15:0] corr;
    logic signed [31:0] cov;
    logic        [31:0] var_a;
    logic        [31:0] var_b;
    logic        [16:0] cnt;
    logic        [1:0]  status;
  } pcs_res_t;

endpackage

// File: design/pearson_correlation_stats.sv
// top level of the pearson correlation statistics block
// depends on pcs_pkg, pcs_front, pcs_fifo and pcs_back

// Takes one sample pair per cycle while full is low. When a pair marked last is
// taken, the run is closed and its sums go to a two-entry queue; the back end
// then works through each run in turn: shift-add products, a combine step, the
// three restoring divides alongside the caa*cbb and cab*cab products, the
// 16-bit root search, and a load of the result register. Runs shorter than two
// pairs or past the count limit skip the arithmetic and go straight to the load.
// full rises while the queue holds two closed runs.
module pearson_correlation_stats (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request input side
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] sample_a_i,
  input  logic signed [15:0] sample_b_i,
  input  logic               last_pair_i,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] correlation_o,
  output logic signed [31:0] covariance_o,
  output logic        [31:0] variance_a_o,
  output logic        [31:0] variance_b_o,
  output logic        [16:0] pair_count_o,
  output logic        [1:0]  status_o
);
  import pcs_pkg::*;

  logic     take, run_push, run_valid, run_pop;
  pcs_run_t run_new, run_head;
  pcs_res_t res;

  // a request is taken when push is high and the queue has room
  assign take = push & ~full;

  pcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .sample_a_i  (sample_a_i),
    .sample_b_i  (sample_b_i),
    .last_pair_i (last_pair_i),
    .run_push_o  (run_push),
    .run_o       (run_new)
  );

  // closed runs wait here while the back end works
  pcs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (run_push),
    .data_i  (run_new),
    .full_o  (full),
    .rd_i    (run_pop),
    .valid_o (run_valid),
    .data_o  (run_head)
  );

  pcs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (run_valid),
    .run_i      (run_head),
    .in_pop_o   (run_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res)
  );

  assign correlation_o = res.corr;
  assign covariance_o  = res.cov;
  assign variance_a_o  = res.var_a;
  assign variance_b_o  = res.var_b;
  assign pair_count_o  = res.cnt;
  assign status_o      = res.status;

endmodule

// File: design/pcs_front.sv
// front part: accumulates count and exact sums per pair, closes a run
// depends on pcs_pkg
module pcs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic        [15:0] sample_a_i,
  input  logic        [15:0] sample_b_i,
  input  logic               last_pair_i,
  output logic               run_push_o,
  output pcs_pkg::pcs_run_t  run_o
);
  import pcs_pkg::*;

  pcs_run_t           acc_q, acc_d;
  logic signed [15:0] a_s, b_s;
  logic signed [31:0] pa, pb, pab;

  assign a_s = 16'(signed'(sample_a_i[SAMPLE_BITS-1:0]));
  assign b_s = 16'(signed'(sample_b_i[SAMPLE_BITS-1:0]));
  assign pa  = a_s * a_s;
  assign pb  = b_s * b_s;
  assign pab = a_s * b_s;

  always_comb begin
    acc_d = acc_q;
    if (acc_q.cnt < 17'(MAX_PAIRS)) begin
      acc_d.cnt = acc_q.cnt + 17'd1;
      acc_d.sa  = acc_q.sa + 33'(a_s);
      acc_d.sb  = acc_q.sb + 33'(b_s);
      acc_d.saa = acc_q.saa + 47'(unsigned'(pa));
      acc_d.sbb = acc_q.sbb + 47'(unsigned'(pb));
      acc_d.sab = acc_q.sab + 48'(pab);
    end else begin
      acc_d.cnt = 17'(MAX_PAIRS + 1);
    end
  end

  assign run_o      = acc_d;
  assign run_push_o = take_i & last_pair_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (take_i) begin
      if (last_pair_i) begin
        acc_q <= '0;
      end else begin
        acc_q <= acc_d;
      end
    end
  end

endmodule

// File: design/pcs_fifo.sv
// two-entry queue of closed runs between front and back
// depends on pcs_pkg
module pcs_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  pcs_pkg::pcs_run_t data_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              valid_o,
  output pcs_pkg::pcs_run_t data_o
);
  import pcs_pkg::*;

  pcs_run_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) begin
        wp_q <= ~wp_q;
      end
      if (rd_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

endmodule

// File: design/pcs_back.sv
// back part: shift-add products, restoring divides, bitwise root search
// depends on pcs_pkg
module pcs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  pcs_pkg::pcs_run_t run_i,
  output logic              in_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output pcs_pkg::pcs_res_t res_o
);
  import pcs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_RT   = 3'd4;
  localparam logic [2:0] S_RC   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [5:0]  it_q;
  pcs_run_t    run_q;
  logic [31:0] abs_sa, abs_sb;
  logic [47:0] abs_sab;
  logic        ovf, few, load_out;

  // product lanes
  logic [31:0] n_sh_q, ma_sh_q, mb_sh_q;
  logic [63:0] mc_aa_q, mc_bb_q, mc_ab_q, mc_a_q, mc_b_q;
  logic [63:0] ac_naa_q, ac_nbb_q, ac_nab_q, ac_aa_q, ac_bb_q, ac_ab_q;
  // combine and divide
  logic signed [63:0] t_nab, t_ab, cab;
  logic [63:0]  caa, cbb, cab_mag;
  logic         cab_neg_q, zero_q;
  logic [31:0]  den_q;
  logic [63:0]  dv_a_q, dv_b_q, dv_c_q;
  logic [31:0]  rm_a_q, rm_b_q, rm_c_q;
  logic [32:0]  tr_a, tr_b, tr_c;
  logic         qa, qb, qc;
  // caa*cbb and cab*cab
  logic [127:0] pm_p_q, pm_c_q, ac_p_q, ac_c_q;
  logic [63:0]  pr_p_q, pr_c_q;
  // root search
  logic [ROOT_W-1:0] rr_q, uu_q, bb_q, tt_q;
  logic [15:0]       q_q;
  logic              take;
  pcs_res_t          res_q, res_d;
  logic              out_valid_q;

  assign abs_sa  = 32'(run_i.sa[32] ? -run_i.sa : run_i.sa);
  assign abs_sb  = 32'(run_i.sb[32] ? -run_i.sb : run_i.sb);
  assign abs_sab = 48'(run_i.sab[47] ? -run_i.sab : run_i.sab);

  assign ovf = (run_q.cnt > 17'(MAX_PAIRS));
  assign few = (run_q.cnt < 17'd2);

  assign in_pop_o = (state_q == S_IDLE) & in_valid_i;
  assign load_out = (state_q == S_DONE) & (!out_valid_q | pop_i);

  assign t_nab   = run_q.sab[47] ? -signed'(ac_nab_q) : signed'(ac_nab_q);
  assign t_ab    = (run_q.sa[32] ^ run_q.sb[32]) ? -signed'(ac_ab_q) : signed'(ac_ab_q);
  assign cab     = t_nab - t_ab;
  assign cab_mag = cab[63] ? unsigned'(-cab) : unsigned'(cab);
  assign caa     = ac_naa_q - ac_aa_q;
  assign cbb     = ac_nbb_q - ac_bb_q;

  assign tr_a = {rm_a_q, dv_a_q[63]};
  assign tr_b = {rm_b_q, dv_b_q[63]};
  assign tr_c = {rm_c_q, dv_c_q[63]};
  assign qa   = (tr_a >= {1'b0, den_q});
  assign qb   = (tr_b >= {1'b0, den_q});
  assign qc   = (tr_c >= {1'b0, den_q});
  assign take = (tt_q <= rr_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if ((run_i.cnt > 17'(MAX_PAIRS)) || (run_i.cnt < 17'd2)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL:  if (it_q == 6'd31) state_d = S_COMB;
      S_COMB: state_d = S_DIV;
      S_DIV:  if (it_q == 6'd63) state_d = S_RT;
      S_RT:   state_d = S_RC;
      S_RC: begin
        state_d = (it_q == 6'd15) ? S_DONE : S_RT;
      end
      S_DONE: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          run_q    <= run_i;
          n_sh_q   <= 32'(run_i.cnt);
          ma_sh_q  <= abs_sa;
          mb_sh_q  <= abs_sb;
          mc_aa_q  <= 64'(run_i.saa);
          mc_bb_q  <= 64'(run_i.sbb);
          mc_ab_q  <= 64'(abs_sab);
          mc_a_q   <= 64'(abs_sa);
          mc_b_q   <= 64'(abs_sb);
          ac_naa_q <= '0;
          ac_nbb_q <= '0;
          ac_nab_q <= '0;
          ac_aa_q  <= '0;
          ac_bb_q  <= '0;
          ac_ab_q  <= '0;
          it_q     <= '0;
        end
      end
      S_MUL: begin
        if (n_sh_q[0]) begin
          ac_naa_q <= ac_naa_q + mc_aa_q;
          ac_nbb_q <= ac_nbb_q + mc_bb_q;
          ac_nab_q <= ac_nab_q + mc_ab_q;
        end
        if (ma_sh_q[0]) ac_aa_q <= ac_aa_q + mc_a_q;
        if (mb_sh_q[0]) begin
          ac_bb_q <= ac_bb_q + mc_b_q;
          ac_ab_q <= ac_ab_q + mc_a_q;
        end
        mc_aa_q <= mc_aa_q << 1;
        mc_bb_q <= mc_bb_q << 1;
        mc_ab_q <= mc_ab_q << 1;
        mc_a_q  <= mc_a_q << 1;
        mc_b_q  <= mc_b_q << 1;
        n_sh_q  <= n_sh_q >> 1;
        ma_sh_q <= ma_sh_q >> 1;
        mb_sh_q <= mb_sh_q >> 1;
        it_q    <= it_q + 6'd1;
      end
      S_COMB: begin
        cab_neg_q <= cab[63];
        zero_q    <= (caa == 64'd0) || (cbb == 64'd0);
        den_q     <= 32'(32'(run_q.cnt) * 32'(run_q.cnt - 17'd1));
        dv_a_q    <= caa;
        dv_b_q    <= cbb;
        dv_c_q    <= cab_mag;
        rm_a_q    <= '0;
        rm_b_q    <= '0;
        rm_c_q    <= '0;
        pm_p_q    <= 128'(caa);
        pr_p_q    <= cbb;
        pm_c_q    <= 128'(cab_mag);
        pr_c_q    <= cab_mag;
        ac_p_q    <= '0;
        ac_c_q    <= '0;
        it_q      <= '0;
      end
      S_DIV: begin
        rm_a_q <= qa ? 32'(tr_a - {1'b0, den_q}) : 32'(tr_a);
        rm_b_q <= qb ? 32'(tr_b - {1'b0, den_q}) : 32'(tr_b);
        rm_c_q <= qc ? 32'(tr_c - {1'b0, den_q}) : 32'(tr_c);
        dv_a_q <= {dv_a_q[62:0], qa};
        dv_b_q <= {dv_b_q[62:0], qb};
        dv_c_q <= {dv_c_q[62:0], qc};
        if (pr_p_q[0]) ac_p_q <= ac_p_q + pm_p_q;
        if (pr_c_q[0]) ac_c_q <= ac_c_q + pm_c_q;
        pm_p_q <= pm_p_q << 1;
        pm_c_q <= pm_c_q << 1;
        pr_p_q <= pr_p_q >> 1;
        pr_c_q <= pr_c_q >> 1;
        it_q   <= it_q + 6'd1;
        if (it_q == 6'd63) begin
          // products complete on this edge, so fold in the last partial
          rr_q <= {(pr_c_q[0] ? ac_c_q + pm_c_q : ac_c_q), 30'd0};
          bb_q <= {(pr_p_q[0] ? ac_p_q + pm_p_q : ac_p_q), 30'd0};
          uu_q <= '0;
          q_q  <= '0;
        end
      end
      S_RT: begin
        tt_q <= (uu_q << 1) + bb_q;
      end
      S_RC: begin
        if (take) rr_q <= rr_q - tt_q;
        uu_q <= (take ? uu_q + bb_q : uu_q) >> 1;
        bb_q <= bb_q >> 2;
        q_q  <= {q_q[14:0], take};
        it_q <= it_q + 6'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_d        = '0;
    res_d.cnt    = run_q.cnt;
    res_d.status = ST_OK;
    if (ovf) begin
      res_d.cnt    = 17'(MAX_PAIRS);
      res_d.status = ST_OVF;
    end else if (few) begin
      res_d.status = ST_FEW;
    end else begin
      res_d.var_a = dv_a_q[31:0];
      res_d.var_b = dv_b_q[31:0];
      res_d.cov   = cab_neg_q ? -signed'(dv_c_q[31:0]) : signed'(dv_c_q[31:0]);
      if (zero_q) begin
        res_d.status = ST_ZVAR;
      end else if (cab_neg_q) begin
        res_d.corr = signed'(-q_q);
      end else begin
        res_d.corr = (q_q > 16'd32767) ? 16'sd32767 : signed'(q_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o = !out_valid_q;
  assign res_o   = res_q;

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for pearson_correlation_stats
// depends on pcs_pkg and the pearson_correlation_stats rtl
`timescale 1ns / 1ps

module tb;
  import pcs_pkg::*;

  typedef enum int {RUN_CONST, RUN_ALT, RUN_RAND, RUN_SAME, RUN_MIRROR, RUN_TINY} run_kind_e;

  // one directed run: how its pairs are formed, and a typed result where obvious
  typedef struct {
    run_kind_e          kind;
    logic signed [15:0] a;
    logic signed [15:0] b;
    int                 len;
    bit                 typed;
    pcs_res_t           res;
  } run_row_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RAND_ITEMS     = 1200;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] sample_a_i = '0;
  logic signed [15:0] sample_b_i = '0;
  logic               last_pair_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] correlation_o;
  logic signed [31:0] covariance_o;
  logic        [31:0] variance_a_o;
  logic        [31:0] variance_b_o;
  logic        [16:0] pair_count_o;
  logic        [1:0]  status_o;

  // predictor state: the block's accumulators, with the sums kept at 64 bits
  logic [16:0] acc_cnt;
  logic [63:0] acc_a, acc_b, acc_aa, acc_bb, acc_ab;

  pcs_res_t stats_due[$];   // results owed by the block, oldest first
  bit       typed_flag[$];  // per closed run: use the typed result instead
  pcs_res_t typed_res[$];

  int  errors = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  items_sent = 0;

  always #5 clk_i = ~clk_i;

  pearson_correlation_stats uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .sample_a_i   (sample_a_i),
    .sample_b_i   (sample_b_i),
    .last_pair_i  (last_pair_i),
    .empty        (empty),
    .pop          (pop),
    .correlation_o(correlation_o),
    .covariance_o (covariance_o),
    .variance_a_o (variance_a_o),
    .variance_b_o (variance_b_o),
    .pair_count_o (pair_count_o),
    .status_o     (status_o)
  );

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // closes the run held in the accumulators and works out its statistics
  function automatic pcs_res_t close_run();
    pcs_res_t    r;
    logic [63:0] n, caa, cbb, cab, cab_mag, den, mag_a, mag_b, cov_mag;
    logic [191:0] prod, rhs, lhs;
    logic [63:0] lo, hi, mid;
    r = '0;
    n = 64'(acc_cnt);
    if (n > MAX_PAIRS) begin
      r.cnt = 17'(MAX_PAIRS);
      r.status = ST_OVF;
    end else if (n < 2) begin
      r.cnt = 17'(n);
      r.status = ST_FEW;
    end else begin
      mag_a = acc_a[63] ? -acc_a : acc_a;
      mag_b = acc_b[63] ? -acc_b : acc_b;
      caa = n * acc_aa - mag_a * mag_a;
      cbb = n * acc_bb - mag_b * mag_b;
      cab = n * acc_ab - acc_a * acc_b;
      cab_mag = cab[63] ? -cab : cab;
      den = n * (n - 1);
      cov_mag = cab_mag / den;
      r.var_a = 32'(caa / den);
      r.var_b = 32'(cbb / den);
      r.cov = 32'(cab[63] ? -cov_mag : cov_mag);
      r.cnt = 17'(n);
      if (caa == 0 || cbb == 0) begin
        r.status = ST_ZVAR;
      end else begin
        // largest q with q*q*caa*cbb <= cab*cab*2^30
        prod = 192'(caa) * 192'(cbb);
        rhs = (192'(cab_mag) * 192'(cab_mag)) << 30;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          lhs = prod * 192'(mid * mid);
          if (lhs <= rhs) lo = mid;
          else hi = mid - 1;
        end
        if (cab[63]) r.corr = 16'(-lo);
        else r.corr = (lo > 32767) ? 16'sd32767 : 16'(lo);
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  // accepted requests feed the predictor, accepted results are checked
  always @(posedge clk_i) begin
    pcs_res_t    want;
    logic [63:0] a64, b64;
    if (rst_ni) begin
      if (push && !full) begin
        a64 = 64'(signed'(sample_a_i));
        b64 = 64'(signed'(sample_b_i));
        if (acc_cnt < MAX_PAIRS) begin
          acc_cnt = acc_cnt + 1;
          acc_a = acc_a + a64;
          acc_b = acc_b + b64;
          acc_aa = acc_aa + a64 * a64;
          acc_bb = acc_bb + b64 * b64;
          acc_ab = acc_ab + a64 * b64;
        end else begin
          acc_cnt = 17'(MAX_PAIRS + 1);
        end
        if (last_pair_i) begin
          want = close_run();
          // directed rows with an obvious answer use the typed one
          if (typed_flag.size() > 0 && typed_flag.pop_front())
            want = typed_res.pop_front();
          stats_due = {stats_due, want};
          acc_cnt = '0;
          {acc_a, acc_b, acc_aa, acc_bb, acc_ab} = '0;
        end
      end
      if (pop && !empty) begin
        if (stats_due.size() == 0) begin
          report("unexpected result", status_o, -1);
        end else begin
          want = stats_due.pop_front();
          if (correlation_o !== want.corr) report("correlation", correlation_o, want.corr);
          if (covariance_o !== want.cov) report("covariance", covariance_o, want.cov);
          if (variance_a_o !== want.var_a) report("variance_a", variance_a_o, want.var_a);
          if (variance_b_o !== want.var_b) report("variance_b", variance_b_o, want.var_b);
          if (pair_count_o !== want.cnt) report("pair_count", pair_count_o, want.cnt);
          if (status_o !== want.status) report("status", status_o, want.status);
        end
      end
    end
  end

  initial begin
    acc_cnt = '0;
    {acc_a, acc_b, acc_aa, acc_bb, acc_ab} = '0;
  end

  // watchdog: cycles with nothing accepted on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL pearson_correlation_stats");
      $finish;
    end
  end

  // receiver: random pop bursts, one long hold so the queue backs up
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
        pop = 1'b1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        pop = 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        pop = 1'b1;
      end
    end
  end

  // one request; called just after a falling edge, returns after one too
  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic last);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    sample_a_i = a;
    sample_b_i = b;
    last_pair_i = last;
    push = 1'b1;
    do @(posedge clk_i); while (full);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_run(input run_kind_e kind, input logic signed [15:0] a,
                          input logic signed [15:0] b, input int len);
    logic signed [15:0] x, y;
    for (int i = 0; i < len; i++) begin
      x = a;
      y = b;
      case (kind)
        RUN_ALT: begin
          if (i % 2) begin
            x = b;
            y = a;
          end
        end
        RUN_RAND: begin
          x = 16'($urandom);
          y = 16'($urandom);
        end
        RUN_SAME: begin
          x = 16'($urandom);
          y = x;
        end
        RUN_MIRROR: begin
          x = 16'($urandom);
          y = ~x;
        end
        RUN_TINY: begin
          x = 16'($urandom_range(0, 8)) - 16'sd4;
          y = 16'($urandom_range(0, 8)) - 16'sd4;
        end
        default: ;
      endcase
      send_pair(x, y, i == len - 1);
    end
  endtask

  function automatic run_row_t row(run_kind_e kind, int a, int b, int len, bit typed,
                                   logic [16:0] cnt, logic [1:0] st);
    run_row_t r;
    r.kind = kind;
    r.a = 16'(a);
    r.b = 16'(b);
    r.len = len;
    r.typed = typed;
    r.res = '0;
    r.res.cnt = cnt;
    r.res.status = st;
    return r;
  endfunction

  initial begin
    run_row_t  rows[$];
    run_kind_e kind;
    int        len;
    // directed runs; constant runs have zero variance and zero covariance
    rows = {rows, row(RUN_CONST, 5, 7, 1, 1, 17'd1, ST_FEW)};
    rows = {rows, row(RUN_CONST, 0, 0, 2, 1, 17'd2, ST_ZVAR)};
    rows = {rows, row(RUN_ALT, 32767, -32768, 2, 0, 0, ST_OK)};
    rows = {rows, row(RUN_ALT, -32768, 32767, 3, 0, 0, ST_OK)};
    rows = {rows, row(RUN_ALT, 100, 200, 2, 0, 0, ST_OK)};
    rows = {rows, row(RUN_ALT, -5, 9, 5, 0, 0, ST_OK)};
    rows = {rows, row(RUN_CONST, 32767, 32767, 4, 1, 17'd4, ST_ZVAR)};
    rows = {rows, row(RUN_CONST, 3, -9, 1, 1, 17'd1, ST_FEW)};
    rows = {rows, row(RUN_SAME, 0, 0, 10, 0, 0, ST_OK)};
    rows = {rows, row(RUN_MIRROR, 0, 0, 10, 0, 0, ST_OK)};
    rows = {rows, row(RUN_RAND, 0, 0, 6, 0, 0, ST_OK)};
    rows = {rows, row(RUN_RAND, 0, 0, 30, 0, 0, ST_OK)};
    rows = {rows, row(RUN_TINY, 0, 0, 8, 0, 0, ST_OK)};
    rows = {rows, row(RUN_CONST, -1, 1, 1, 1, 17'd1, ST_FEW)};

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      typed_flag = {typed_flag, rows[i].typed};
      if (rows[i].typed) typed_res = {typed_res, rows[i].res};
      send_run(rows[i].kind, rows[i].a, rows[i].b, rows[i].len);
    end

    // random runs: mostly short, so the result queue sees back-pressure
    items_sent = 0;
    hold_req = 1'b1;
    while (items_sent < RAND_ITEMS) begin
      if (items_sent > RAND_ITEMS - 200) no_idle = 1'b1;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0: kind = RUN_CONST;
        1: kind = RUN_ALT;
        2: kind = RUN_SAME;
        3: kind = RUN_MIRROR;
        4, 5: kind = RUN_TINY;
        default: kind = RUN_RAND;
      endcase
      typed_flag = {typed_flag, 1'b0};
      send_run(kind, 16'($urandom), 16'($urandom), len);
    end
    push = 1'b0;

    while (stats_due.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && stats_due.size() == 0) begin
      $display("PASS pearson_correlation_stats");
    end else begin
      $display("FAIL pearson_correlation_stats");
    end
    $finish;
  end

endmodule

// File: pearson_correlation_stats.f
design/pcs_pkg.sv
design/pcs_front.sv
design/pcs_fifo.sv
design/pcs_back.sv
design/pearson_correlation_stats.sv
tb/sv/tb.sv
